[design/bpm_pkg.sv]
// Shared types and constants for the pixel blend block.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps

package bpm_pkg;

  localparam int CHANNELS = 3;   // blue, green, red
  localparam int PIX_W    = 8;
  localparam int MUL_W    = 2 * PIX_W;   // raw 8x8 product
  localparam int PROD_W   = MUL_W + 1;   // product with optional doubling
  localparam int QUO_W    = PIX_W + 1;   // rounded quotient, up to 510
  localparam int MODE_W   = 3;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 3;
  localparam int IDX_W    = 1;

  localparam logic [IDX_W-1:0] REG_BLEND_MODE = 1'b0;

  // Rounding bias: round(n/255) == floor((n + 127)/255) for integer n.
  localparam logic [PROD_W-1:0] ROUND_BIAS = PROD_W'(127);
  localparam logic [PIX_W-1:0]  PIX_MAX    = {PIX_W{1'b1}};

  typedef enum logic [MODE_W-1:0] {
    MODE_MULTIPLY = 3'd0,
    MODE_SCREEN   = 3'd1,
    MODE_SUBTRACT = 3'd2,
    MODE_ADD      = 3'd3,
    MODE_OVERLAY  = 3'd4
  } mode_t;

  // What the second stage does with the stored value.
  typedef enum logic [1:0] {
    POST_DIRECT = 2'd0,   // value already final in the low byte
    POST_DIV    = 2'd1,   // round(n/255), clamp to 255
    POST_INV    = 2'd2    // 255 - round(n/255), floor at 0
  } post_t;

  typedef struct packed {
    logic s1_valid;   // first stage holds an item
    logic out_load;   // move first stage into the output register
  } ctrl_t;

endpackage

[design/bpm_in_if.sv]
// Input channel of the blend block: one top and one bottom BGR pixel.
// Depends on bpm_pkg.
`timescale 1ns / 1ps

interface bpm_in_if;
  import bpm_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] top_blue;
  logic [PIX_W-1:0] top_green;
  logic [PIX_W-1:0] top_red;
  logic [PIX_W-1:0] bottom_blue;
  logic [PIX_W-1:0] bottom_green;
  logic [PIX_W-1:0] bottom_red;

  modport source (
    output valid, top_blue, top_green, top_red, bottom_blue, bottom_green, bottom_red,
    input  ready
  );

  modport sink (
    input  valid, top_blue, top_green, top_red, bottom_blue, bottom_green, bottom_red,
    output ready
  );
endinterface

[design/bpm_out_if.sv]
// Output channel of the blend block: one blended BGR pixel.
// Depends on bpm_pkg.
`timescale 1ns / 1ps

interface bpm_out_if;
  import bpm_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] blend_blue;
  logic [PIX_W-1:0] blend_green;
  logic [PIX_W-1:0] blend_red;

  modport source (
    output valid, blend_blue, blend_green, blend_red,
    input  ready
  );

  modport sink (
    input  valid, blend_blue, blend_green, blend_red,
    output ready
  );
endinterface

[design/pixel_blend_modes.sv]
// Blend of a top and a bottom BGR pixel under a mode register.
// Pipeline: an accepted item is registered in the lane stage, then in the output register.
// Throughput: one item per cycle while the receiver keeps taking results; the three channel lanes
// work in parallel and each stage advances whenever the stage after it can take its item.
// Reset: synchronous, active high; clears both stage valids and sets blend_mode to multiply.
// Depends on bpm_pkg, bpm_in_if, bpm_out_if, bpm_lane and bpm_merge.
`timescale 1ns / 1ps

module pixel_blend_modes (
  input  logic                          clk,
  input  logic                          rst,
  bpm_in_if.sink                        pixels,
  bpm_out_if.source                     blended,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bpm_pkg::ADDR_W-1:0]    paddr,
  input  logic [bpm_pkg::DATA_W-1:0]    pwdata,
  output logic [bpm_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import bpm_pkg::*;

  mode_t            blend_mode;
  logic [IDX_W-1:0] reg_idx;
  logic             cfg_write;

  logic             s1_valid;
  logic             out_free;
  logic             take;
  ctrl_t            ctrl;

  logic [PIX_W-1:0] top_ch    [CHANNELS];
  logic [PIX_W-1:0] bottom_ch [CHANNELS];
  logic [PIX_W-1:0] lane_res  [CHANNELS];

  // Configuration port: register index is the word address.
  assign pready    = 1'b1;
  assign reg_idx   = paddr[ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_mode <= MODE_MULTIPLY;
    end else if (cfg_write && reg_idx == REG_BLEND_MODE) begin
      // keep the low bits only; unused codes pass the top pixel through
      blend_mode <= mode_t'(pwdata[MODE_W-1:0]);
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BLEND_MODE: prdata = {{(DATA_W-MODE_W){1'b0}}, blend_mode};
      default:        prdata = '0;
    endcase
  end

  // Pipeline control: the output register frees when empty or taken,
  // and the lane stage advances whenever the output register can take it.
  assign out_free     = !blended.valid || blended.ready;
  assign pixels.ready = !s1_valid || out_free;
  assign take         = pixels.valid && pixels.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pixels.ready) begin
      // a held item moves out in this same cycle, so refill or drain
      s1_valid <= pixels.valid;
    end
  end

  assign ctrl.s1_valid = s1_valid;
  assign ctrl.out_load = s1_valid && out_free;

  // Spread the pixel into per-channel lanes, blue first.
  assign top_ch[0]    = pixels.top_blue;
  assign top_ch[1]    = pixels.top_green;
  assign top_ch[2]    = pixels.top_red;
  assign bottom_ch[0] = pixels.bottom_blue;
  assign bottom_ch[1] = pixels.bottom_green;
  assign bottom_ch[2] = pixels.bottom_red;

  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    bpm_lane u_lane (
      .clk    (clk),
      .ctrl   (ctrl),
      .load   (take),
      .mode   (blend_mode),
      .a      (top_ch[c]),
      .b      (bottom_ch[c]),
      .result (lane_res[c])
    );
  end

  // Gather the lanes into the output register.
  bpm_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .lane_res (lane_res),
    .blended  (blended)
  );

endmodule

[design/bpm_lane.sv]
// One channel lane: operand select and multiply, registered, then
// divide-by-255 rounding and final mapping. Depends on bpm_pkg.
`timescale 1ns / 1ps

module bpm_lane (
  input  logic                       clk,
  input  bpm_pkg::ctrl_t             ctrl,
  input  logic                       load,
  input  bpm_pkg::mode_t             mode,
  input  logic [bpm_pkg::PIX_W-1:0]  a,
  input  logic [bpm_pkg::PIX_W-1:0]  b,
  output logic [bpm_pkg::PIX_W-1:0]  result
);
  import bpm_pkg::*;

  logic [PIX_W-1:0]  op_x;
  logic [PIX_W-1:0]  op_y;
  logic              op_dbl;
  logic              op_direct;
  logic [PIX_W-1:0]  direct_val;
  post_t             post_sel;
  logic [PIX_W:0]    sum;
  logic [MUL_W-1:0]  mul;
  logic [PROD_W-1:0] prod_sel;

  // first stage registers (payload, no reset)
  post_t             post;
  logic [PROD_W-1:0] prod;

  logic [PROD_W-1:0] x;
  logic [PROD_W-1:0] est_sum;
  logic [QUO_W-1:0]  q1;
  logic [PROD_W-1:0] q1_x255;
  logic [PROD_W-1:0] rem;
  logic [QUO_W-1:0]  quo;

  assign sum = {1'b0, a} + {1'b0, b};

  always_comb begin
    op_x       = a;
    op_y       = b;
    op_dbl     = 1'b0;
    op_direct  = 1'b0;
    direct_val = a;
    post_sel   = POST_DIV;
    case (mode)
      MODE_MULTIPLY: begin
        post_sel = POST_DIV;
      end
      MODE_SCREEN: begin
        op_x     = ~a;
        op_y     = ~b;
        post_sel = POST_INV;
      end
      MODE_SUBTRACT: begin
        op_direct  = 1'b1;
        direct_val = (a > b) ? (a - b) : '0;
      end
      MODE_ADD: begin
        op_direct  = 1'b1;
        direct_val = sum[PIX_W] ? PIX_MAX : sum[PIX_W-1:0];
      end
      MODE_OVERLAY: begin
        op_dbl = 1'b1;
        if (b[PIX_W-1]) begin
          op_x     = ~a;
          op_y     = ~b;
          post_sel = POST_INV;
        end else begin
          post_sel = POST_DIV;
        end
      end
      default: begin
        // unused codes pass the top channel through
        op_direct  = 1'b1;
        direct_val = a;
      end
    endcase
  end

  assign mul = op_x * op_y;

  always_comb begin
    if (op_direct) begin
      prod_sel = {{(PROD_W-PIX_W){1'b0}}, direct_val};
    end else if (op_dbl) begin
      prod_sel = {mul, 1'b0};
    end else begin
      prod_sel = {1'b0, mul};
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      post <= op_direct ? POST_DIRECT : post_sel;
      prod <= prod_sel;
    end
  end

  // Second stage: floor(x/255) by estimate and one correction step.
  assign x       = prod + ROUND_BIAS;
  assign est_sum = x + (x >> 8) + PROD_W'(1);
  assign q1      = est_sum[PROD_W-1:8];
  assign q1_x255 = {q1, 8'b0} - {{(PROD_W-QUO_W){1'b0}}, q1};
  assign rem     = x - q1_x255;

  always_comb begin
    if (x < q1_x255) begin
      quo = q1 - QUO_W'(1);
    end else if (rem >= PROD_W'(PIX_MAX)) begin
      quo = q1 + QUO_W'(1);
    end else begin
      quo = q1;
    end
  end

  always_comb begin
    case (post)
      POST_DIRECT: result = prod[PIX_W-1:0];
      POST_DIV:    result = quo[PIX_W] ? PIX_MAX : quo[PIX_W-1:0];
      POST_INV:    result = quo[PIX_W] ? '0 : (PIX_MAX - quo[PIX_W-1:0]);
      default:     result = prod[PIX_W-1:0];
    endcase
    // an empty stage drives zero so nothing stale reaches the merge
    if (!ctrl.s1_valid) begin
      result = '0;
    end
  end

endmodule

[design/bpm_merge.sv]
// Merge stage: gathers the lane results into the output register and
// drives the output channel. Depends on bpm_pkg and bpm_out_if.
`timescale 1ns / 1ps

module bpm_merge (
  input  logic                              clk,
  input  logic                              rst,
  input  bpm_pkg::ctrl_t                    ctrl,
  input  logic [bpm_pkg::PIX_W-1:0]         lane_res [bpm_pkg::CHANNELS],
  bpm_out_if.source                         blended
);
  import bpm_pkg::*;

  logic             out_valid;
  logic [PIX_W-1:0] px [CHANNELS];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || blended.ready) begin
      out_valid <= ctrl.s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      px <= lane_res;
    end
  end

  assign blended.valid       = out_valid;
  assign blended.blend_blue  = px[0];
  assign blended.blend_green = px[1];
  assign blended.blend_red   = px[2];

endmodule

[design/bpm_checker.sv]
// Port-level checks for the pixel blend block, bound to the top level.
// Depends on pixel_blend_modes and bpm_pkg.
`timescale 1ns / 1ps

module bpm_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [bpm_pkg::PIX_W-1:0]    out_blue,
  input logic [bpm_pkg::PIX_W-1:0]    out_green,
  input logic [bpm_pkg::PIX_W-1:0]    out_red
);
  import bpm_pkg::*;

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_blue) &&
                                $stable(out_green) && $stable(out_red))
    else $error("stalled output item changed or dropped");

  // reset empties the output side
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // a result appears only for an input item taken in and passed through the lane stage
  a_rise_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("output item without matching input item");

  // input stalls only when the output is full and held
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while output could move");

endmodule

bind pixel_blend_modes bpm_checker u_bpm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pixels.valid),
  .in_ready  (pixels.ready),
  .out_valid (blended.valid),
  .out_ready (blended.ready),
  .out_blue  (blended.blend_blue),
  .out_green (blended.blend_green),
  .out_red   (blended.blend_red)
);

[tb/sv/testbench.sv]
// Self-checking regression for pixel_blend_modes: blend-mode register writes over APB,
// a directed table and random pixel streams, checked against hand-worked results or an in-bench predictor.
// Depends on bpm_pkg, bpm_in_if, bpm_out_if and the pixel_blend_modes RTL.
`timescale 1ns / 1ps

module testbench;
  import bpm_pkg::*;

  localparam int DIRECTED_ROWS  = 20;
  localparam int PHASE_ITEMS    = 77;       // random items per mode setting
  localparam int HOLDOFF_CYCLES = 300;      // long receiver stall, fills the pipeline
  localparam int SETTLE_CYCLES  = 6;        // lets the lane stage and output register settle, with margin
  localparam int CYCLE_LIMIT    = 400000;

  // Register 0 sits at byte address 0; address 4 decodes to an index with no register.
  localparam logic [ADDR_W-1:0] MODE_ADDR     = ADDR_W'({REG_BLEND_MODE, 2'b00});
  localparam logic [ADDR_W-1:0] UNMAPPED_ADDR = ADDR_W'(4);

  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } bgr_t;

  // One row of the directed table: optional register write ahead of the item, the item
  // itself, and a hand-worked result where one is easy to read off.
  typedef struct packed {
    logic              do_write;
    logic [ADDR_W-1:0] waddr;
    logic [31:0]       wdata;
    bgr_t              top;
    bgr_t              bottom;
    logic              pinned;
    bgr_t              want;
  } dir_row_t;

  localparam dir_row_t DIRECTED [DIRECTED_ROWS] = '{
    // multiply straight out of reset: 255 is the identity, 0 annihilates
    '{1'b0, MODE_ADDR, 32'h0, '{8'hff, 8'hff, 8'hff}, '{8'hff, 8'h80, 8'h00},
      1'b1, '{8'hff, 8'h80, 8'h00}},
    '{1'b0, MODE_ADDR, 32'h0, '{8'h00, 8'h00, 8'h00}, '{8'hff, 8'hff, 8'hff},
      1'b1, '{8'h00, 8'h00, 8'h00}},
    '{1'b0, MODE_ADDR, 32'h0, '{8'h80, 8'h7f, 8'hc3}, '{8'h80, 8'h80, 8'h5a},
      1'b0, '{8'h00, 8'h00, 8'h00}},
    // screen: black on black stays black, white on anything is white
    '{1'b1, MODE_ADDR, 32'(MODE_SCREEN), '{8'h00, 8'h00, 8'h00}, '{8'h00, 8'h00, 8'h00},
      1'b1, '{8'h00, 8'h00, 8'h00}},
    '{1'b0, MODE_ADDR, 32'h0, '{8'hff, 8'h00, 8'h55}, '{8'h00, 8'hff, 8'haa},
      1'b0, '{8'h00, 8'h00, 8'h00}},
    // subtract: floors at zero
    '{1'b1, MODE_ADDR, 32'(MODE_SUBTRACT), '{8'h10, 8'hff, 8'h80}, '{8'h20, 8'h00, 8'h80},
      1'b1, '{8'h00, 8'hff, 8'h00}},
    // add: saturates at 255
    '{1'b1, MODE_ADDR, 32'(MODE_ADD), '{8'hff, 8'h00, 8'h80}, '{8'h01, 8'h00, 8'h80},
      1'b1, '{8'hff, 8'h00, 8'hff}},
    '{1'b0, MODE_ADDR, 32'h0, '{8'h12, 8'h34, 8'h56}, '{8'h78, 8'h9a, 8'hbc},
      1'b0, '{8'h00, 8'h00, 8'h00}},
    // overlay: either side of the bottom = 127/128 split
    '{1'b1, MODE_ADDR, 32'(MODE_OVERLAY), '{8'hff, 8'h00, 8'hff}, '{8'h7f, 8'h7f, 8'h80},
      1'b1, '{8'hfe, 8'h00, 8'hff}},
    '{1'b0, MODE_ADDR, 32'h0, '{8'h00, 8'h80, 8'hff}, '{8'h80, 8'hff, 8'h00},
      1'b1, '{8'h01, 8'hff, 8'h00}},
    '{1'b0, MODE_ADDR, 32'h0, '{8'h40, 8'hc0, 8'h7f}, '{8'h7f, 8'h80, 8'hc0},
      1'b0, '{8'h00, 8'h00, 8'h00}},
    // unused mode codes pass the top pixel through
    '{1'b1, MODE_ADDR, 32'h5, '{8'h5a, 8'ha5, 8'h3c}, '{8'hff, 8'h00, 8'hff},
      1'b1, '{8'h5a, 8'ha5, 8'h3c}},
    '{1'b1, MODE_ADDR, 32'h6, '{8'h00, 8'hff, 8'h81}, '{8'h11, 8'h22, 8'h33},
      1'b1, '{8'h00, 8'hff, 8'h81}},
    '{1'b1, MODE_ADDR, 32'h7, '{8'hc3, 8'h3c, 8'hff}, '{8'h00, 8'h00, 8'h00},
      1'b1, '{8'hc3, 8'h3c, 8'hff}},
    // wide write: only the low three bits land, here screen
    '{1'b1, MODE_ADDR, 32'hffff_fff9, '{8'h00, 8'h00, 8'h00}, '{8'h00, 8'h00, 8'h00},
      1'b1, '{8'h00, 8'h00, 8'h00}},
    // write to an unmapped index must leave screen in place
    '{1'b1, UNMAPPED_ADDR, 32'(MODE_MULTIPLY), '{8'hff, 8'hff, 8'hff}, '{8'h00, 8'h00, 8'h00},
      1'b1, '{8'hff, 8'hff, 8'hff}},
    '{1'b0, MODE_ADDR, 32'h0, '{8'h80, 8'h40, 8'hc0}, '{8'h80, 8'hc0, 8'h40},
      1'b0, '{8'h00, 8'h00, 8'h00}},
    '{1'b1, MODE_ADDR, 32'haaaa_aaaa, '{8'h55, 8'haa, 8'h00}, '{8'haa, 8'h55, 8'h00},
      1'b1, '{8'h00, 8'h55, 8'h00}},
    '{1'b1, MODE_ADDR, 32'h5555_5554, '{8'h80, 8'h80, 8'h80}, '{8'h7f, 8'h80, 8'h81},
      1'b0, '{8'h00, 8'h00, 8'h00}},
    '{1'b1, MODE_ADDR, 32'(MODE_MULTIPLY), '{8'h01, 8'hfe, 8'hff}, '{8'h01, 8'hfe, 8'h01},
      1'b0, '{8'h00, 8'h00, 8'h00}}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  bpm_in_if  pixels ();
  bpm_out_if blended ();

  pixel_blend_modes dut (
    .clk     (clk),
    .rst     (rst),
    .pixels  (pixels),
    .blended (blended),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor state: the blend mode the block should be holding.
  logic [MODE_W-1:0] mode_shadow = MODE_W'(MODE_MULTIPLY);
  bgr_t              blends_due [$];
  int                mismatches = 0;
  int                cycle_count = 0;

  // Idle rates in percent; changed only at clock edges by the stimulus thread.
  int   send_idle_pct = 32;
  int   recv_idle_pct = 57;
  logic hold_token = 1'b0;
  logic hold_seen  = 1'b0;
  int   hold_left  = 0;

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------------------

  // round(n/255) in integers; never lands on a half for these operands
  function automatic int unsigned round_div255(int unsigned n);
    return (2 * n + 255) / 510;
  endfunction

  function automatic logic [PIX_W-1:0] blend_channel(logic [MODE_W-1:0] mode,
                                                     logic [PIX_W-1:0] a,
                                                     logic [PIX_W-1:0] b);
    int unsigned x;
    int unsigned y;
    int unsigned v;
    int unsigned d;
    x = a;
    y = b;
    case (mode)
      MODE_MULTIPLY: v = round_div255(x * y);
      MODE_SCREEN:   v = 255 - round_div255((255 - x) * (255 - y));
      MODE_SUBTRACT: v = (x > y) ? x - y : 0;
      MODE_ADD:      v = (x + y > 255) ? 255 : x + y;
      MODE_OVERLAY: begin
        if (y <= 127) begin
          v = round_div255(2 * x * y);
          if (v > 255) v = 255;
        end else begin
          d = round_div255(2 * (255 - x) * (255 - y));
          v = (d > 255) ? 0 : 255 - d;
        end
      end
      default:       v = x;   // unused codes pass the top channel through
    endcase
    return v[PIX_W-1:0];
  endfunction

  function automatic bgr_t blend_pixel(bgr_t top, bgr_t bottom);
    bgr_t r;
    r.blue  = blend_channel(mode_shadow, top.blue,  bottom.blue);
    r.green = blend_channel(mode_shadow, top.green, bottom.green);
    r.red   = blend_channel(mode_shadow, top.red,   bottom.red);
    return r;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------------------

  // Weight towards the corners of the byte range, where clamping and the overlay split live.
  function automatic logic [PIX_W-1:0] pick_byte();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hff;
      2:       return 8'h7f;
      3:       return 8'h80;
      default: return PIX_W'($urandom_range(255));
    endcase
  endfunction

  function automatic bgr_t pick_pixel();
    bgr_t p;
    p.blue  = pick_byte();
    p.green = pick_byte();
    p.red   = pick_byte();
    return p;
  endfunction

  // APB write: setup then access, hold until pready; mirror the effect in the predictor.
  // Close by dropping psel so a following write starts on a fresh setup phase.
  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    if (addr[ADDR_W-1:2] == REG_BLEND_MODE) mode_shadow = data[MODE_W-1:0];
  endtask

  // Offer one item, idling each cycle with the sender's idle rate first; log the expected
  // blend once it is taken.
  task automatic offer_pixel(input bgr_t top, input bgr_t bottom,
                             input logic pinned, input bgr_t want);
    if ($urandom_range(99) < send_idle_pct) begin
      pixels.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    pixels.valid        <= 1'b1;
    pixels.top_blue     <= top.blue;
    pixels.top_green    <= top.green;
    pixels.top_red      <= top.red;
    pixels.bottom_blue  <= bottom.blue;
    pixels.bottom_green <= bottom.green;
    pixels.bottom_red   <= bottom.red;
    do @(posedge clk); while (!pixels.ready);
    blends_due = {blends_due, (pinned ? want : blend_pixel(top, bottom))};
  endtask

  // Drop valid, wait for every outstanding blend, then let the pipeline settle.
  task automatic drain();
    pixels.valid <= 1'b0;
    while (blends_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------------------
  // Receiver: random back-pressure, plus a long hold-off on request
  // ---------------------------------------------------------------------------------------

  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen     <= hold_token;
      hold_left     <= HOLDOFF_CYCLES;
      blended.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      blended.ready <= 1'b0;
    end else begin
      blended.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------------------
  // Result checker: compare each accepted item with the oldest expectation
  // ---------------------------------------------------------------------------------------

  always @(posedge clk) begin : check_blends
    bgr_t want;
    if (!rst && blended.valid && blended.ready) begin
      if (blends_due.size() == 0) begin
        $error("blended item with nothing expected: %h %h %h",
               blended.blend_blue, blended.blend_green, blended.blend_red);
        mismatches++;
      end else begin
        want = blends_due.pop_front();
        if (blended.blend_blue !== want.blue) begin
          $error("blend_blue: expected %h, got %h", want.blue, blended.blend_blue);
          mismatches++;
        end
        if (blended.blend_green !== want.green) begin
          $error("blend_green: expected %h, got %h", want.green, blended.blend_green);
          mismatches++;
        end
        if (blended.blend_red !== want.red) begin
          $error("blend_red: expected %h, got %h", want.red, blended.blend_red);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("pixel_blend_modes regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------------------

  initial begin : stimulus
    bgr_t        top;
    bgr_t        bottom;
    logic [2:0]  code;
    int          regime;
    // hold every input at a known level from time zero
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    pixels.valid        <= 1'b0;
    pixels.top_blue     <= '0;
    pixels.top_green    <= '0;
    pixels.top_red      <= '0;
    pixels.bottom_blue  <= '0;
    pixels.bottom_green <= '0;
    pixels.bottom_red   <= '0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table: drain before any write so the mode only changes while idle.
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      if (DIRECTED[i].do_write) begin
        drain();
        write_reg(DIRECTED[i].waddr, DIRECTED[i].wdata);
      end
      offer_pixel(DIRECTED[i].top, DIRECTED[i].bottom, DIRECTED[i].pinned, DIRECTED[i].want);
    end

    // Random part: three idle regimes (sender light / receiver heavy, swapped, none),
    // each sweeping all eight mode codes including the pass-through ones.
    for (int phase = 0; phase < 24; phase++) begin
      regime = phase / 8;
      code   = 3'(phase % 8);
      drain();
      case (regime)
        0:       begin send_idle_pct <= 32; recv_idle_pct <= 57; end
        1:       begin send_idle_pct <= 57; recv_idle_pct <= 32; end
        default: begin send_idle_pct <= 0;  recv_idle_pct <= 0;  end
      endcase
      // junk in the upper bits must be dropped; stray writes to the unmapped index ignored
      if ($urandom_range(1) == 1) write_reg(UNMAPPED_ADDR, $urandom());
      write_reg(MODE_ADDR, {29'($urandom_range(32'h1fff_ffff)), code});
      // once, with the sender flat out, stall the receiver long enough to back up the input
      if (regime == 2 && code == 3'(MODE_OVERLAY)) hold_token <= ~hold_token;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        top    = pick_pixel();
        // sometimes mirror the top pixel: equal operands hit subtract's zero edge
        bottom = ($urandom_range(7) == 0) ? top : pick_pixel();
        offer_pixel(top, bottom, 1'b0, '0);
      end
    end

    drain();
    if (mismatches == 0 && blends_due.size() == 0) begin
      $display("pixel_blend_modes regression: pass");
    end else begin
      $display("pixel_blend_modes regression: fail");
    end
    $finish;
  end

endmodule

[sim.f]
design/bpm_pkg.sv
design/bpm_in_if.sv
design/bpm_out_if.sv
design/bpm_lane.sv
design/bpm_merge.sv
design/pixel_blend_modes.sv
design/bpm_checker.sv
tb/sv/testbench.sv
